FILE: design/tmcw_pkg.sv
// Shared types and constants of the text markup cell writer.
`timescale 1ns / 1ps
`default_nettype none

package tmcw_pkg;

    // Payload and state types
    typedef logic [7:0]  char_t;
    typedef logic [5:0]  start_col_t;
    typedef logic [4:0]  start_row_t;
    typedef logic [10:0] cell_index_t;
    typedef logic [15:0] color_t;
    typedef logic [6:0]  cols_cfg_t;
    typedef logic [5:0]  rows_cfg_t;
    // Cursor registers hold up to the largest supported bound (127 columns, 63 rows)
    typedef logic [7:0]  col_t;
    typedef logic [6:0]  row_t;

    // Configuration register indexes
    typedef logic [2:0] cfg_index_t;
    localparam cfg_index_t REG_TEXT_COLOR      = 3'd0;
    localparam cfg_index_t REG_SPECIAL_COLOR   = 3'd1;
    localparam cfg_index_t REG_BACKGROUND      = 3'd2;
    localparam cfg_index_t REG_HIGHLIGHT_COLOR = 3'd3;
    localparam cfg_index_t REG_COLUMNS_IN_USE  = 3'd4;
    localparam cfg_index_t REG_ROWS_IN_USE     = 3'd5;

    localparam cols_cfg_t COLUMNS_RESET = 7'd64;
    localparam rows_cfg_t ROWS_RESET    = 6'd32;

    // Character codes
    localparam char_t CH_NUL         = 8'h00;
    localparam char_t CH_LF          = 8'h0A;
    localparam char_t CH_CR          = 8'h0D;
    localparam char_t CH_SPECIAL_ON  = 8'h5B;
    localparam char_t CH_SPECIAL_OFF = 8'h5D;
    localparam char_t CH_HILITE_ON   = 8'h7B;
    localparam char_t CH_UNDERLINE   = 8'h7C;
    localparam char_t CH_HILITE_OFF  = 8'h7D;
    localparam char_t UNDERLINE_BIT  = 8'h80;

endpackage

`default_nettype wire

FILE: design/tmcw_char_if.sv
// Character request channel of the text markup cell writer.
`timescale 1ns / 1ps
`default_nettype none

interface tmcw_char_if;
    logic                    valid;
    logic                    ready;
    tmcw_pkg::char_t         char_code;
    logic                    first;
    tmcw_pkg::start_col_t    start_col;
    tmcw_pkg::start_row_t    start_row;

    modport source (output valid, output char_code, output first,
                    output start_col, output start_row, input ready);
    modport sink   (input valid, input char_code, input first,
                    input start_col, input start_row, output ready);
endinterface

`default_nettype wire

FILE: design/tmcw_cell_if.sv
// Cell write request channel of the text markup cell writer.
`timescale 1ns / 1ps
`default_nettype none

interface tmcw_cell_if;
    logic                    valid;
    logic                    ready;
    tmcw_pkg::cell_index_t   cell_index;
    tmcw_pkg::char_t         cell_char;
    tmcw_pkg::color_t        cell_fg_color;
    tmcw_pkg::color_t        cell_bg_color;

    modport source (output valid, output cell_index, output cell_char,
                    output cell_fg_color, output cell_bg_color, input ready);
    modport sink   (input valid, input cell_index, input cell_char,
                    input cell_fg_color, input cell_bg_color, output ready);
endinterface

`default_nettype wire

FILE: design/tmcw_cfg_if.sv
// Configuration write channel of the text markup cell writer.
`timescale 1ns / 1ps
`default_nettype none

interface tmcw_cfg_if;
    logic                    valid;
    logic                    ready;
    tmcw_pkg::cfg_index_t    index;
    tmcw_pkg::color_t        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/text_markup_cell_writer.sv
// Top level: decodes string characters and issues text cell writes.
// A cell write request turns valid in the cycle after its character is accepted.
// Throughput: one character per cycle unless the output holds an untaken request.
// Characters that write no cell produce no request.
// Reset: cursor and markup flags clear, the string counts as stopped until a first
// character, colors reset to zero, bounds to 64 columns and 32 rows.
`timescale 1ns / 1ps
`default_nettype none

module text_markup_cell_writer #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 32
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tmcw_char_if.sink   char_in,
    tmcw_cell_if.source cell_out,
    tmcw_cfg_if.sink    cfg
);
    import tmcw_pkg::*;

    localparam col_t MAX_COL_BOUND = col_t'(MAX_COLS);
    localparam row_t MAX_ROW_BOUND = row_t'(MAX_ROWS);

    // Configuration registers
    color_t    text_color_reg;
    color_t    special_color_reg;
    color_t    background_reg;
    color_t    highlight_color_reg;
    cols_cfg_t columns_in_use_reg;
    rows_cfg_t rows_in_use_reg;

    // String state
    col_t cursor_col_reg, cursor_col_next;
    row_t cursor_row_reg, cursor_row_next;
    logic special_on_reg, special_on_next;
    logic highlight_on_reg, highlight_on_next;
    logic underline_on_reg, underline_on_next;
    logic stopped_reg, stopped_next;

    // Output register
    logic        out_valid_reg;
    cell_index_t cell_index_reg, cell_index_next;
    char_t       cell_char_reg, cell_char_next;
    color_t      fg_color_reg, fg_color_next;
    color_t      bg_color_reg, bg_color_next;

    logic   in_accept;
    logic   write_cell;
    col_t   col_limit;
    row_t   row_limit;
    col_t   cur_col;
    row_t   cur_row;
    logic   cur_special;
    logic   cur_highlight;
    logic   cur_underline;
    logic   cur_stopped;
    logic   [13:0] index_full;

    assign cfg.ready     = 1'b1;
    assign char_in.ready = !out_valid_reg || cell_out.ready;
    assign in_accept     = char_in.valid && char_in.ready;

    // Take configuration writes; drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg      <= '0;
            special_color_reg   <= '0;
            background_reg      <= '0;
            highlight_color_reg <= '0;
            columns_in_use_reg  <= COLUMNS_RESET;
            rows_in_use_reg     <= ROWS_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_TEXT_COLOR:      text_color_reg      <= cfg.data;
                REG_SPECIAL_COLOR:   special_color_reg   <= cfg.data;
                REG_BACKGROUND:      background_reg      <= cfg.data;
                REG_HIGHLIGHT_COLOR: highlight_color_reg <= cfg.data;
                REG_COLUMNS_IN_USE:  columns_in_use_reg  <= cfg.data[6:0];
                REG_ROWS_IN_USE:     rows_in_use_reg     <= cfg.data[5:0];
                default:             ;
            endcase
        end
    end

    // Clamp screen bounds to the buffer size
    assign col_limit = ({1'b0, columns_in_use_reg} < MAX_COL_BOUND)
                     ? {1'b0, columns_in_use_reg} : MAX_COL_BOUND;
    assign row_limit = ({1'b0, rows_in_use_reg} < MAX_ROW_BOUND)
                     ? {1'b0, rows_in_use_reg} : MAX_ROW_BOUND;

    // Load start position and clear flags on the first character of a string
    always_comb
    begin
        if (char_in.first)
        begin
            cur_col       = {2'b00, char_in.start_col};
            cur_row       = {2'b00, char_in.start_row};
            cur_special   = 1'b0;
            cur_highlight = 1'b0;
            cur_underline = 1'b0;
            cur_stopped   = 1'b0;
        end
        else
        begin
            cur_col       = cursor_col_reg;
            cur_row       = cursor_row_reg;
            cur_special   = special_on_reg;
            cur_highlight = highlight_on_reg;
            cur_underline = underline_on_reg;
            cur_stopped   = stopped_reg;
        end
    end

    assign index_full = 14'(cur_row) * 14'(MAX_COLS) + 14'(cur_col);

    // Decode the character and advance the cursor
    always_comb
    begin
        cursor_col_next   = cur_col;
        cursor_row_next   = cur_row;
        special_on_next   = cur_special;
        highlight_on_next = cur_highlight;
        underline_on_next = cur_underline;
        stopped_next      = cur_stopped;
        write_cell        = 1'b0;

        if (!cur_stopped)
        begin
            if (char_in.char_code == CH_NUL || cur_col >= col_limit
                || cur_row >= row_limit)
            begin
                stopped_next = 1'b1;
            end
            else
            begin
                case (char_in.char_code) inside
                    CH_CR, CH_LF:    cursor_row_next   = cur_row + 7'd1;
                    CH_SPECIAL_ON:   special_on_next   = 1'b1;
                    CH_SPECIAL_OFF:  special_on_next   = 1'b0;
                    CH_HILITE_ON:    highlight_on_next = 1'b1;
                    CH_HILITE_OFF:   highlight_on_next = 1'b0;
                    CH_UNDERLINE:    underline_on_next = !cur_underline;
                    default:
                    begin
                        write_cell      = 1'b1;
                        cursor_col_next = cur_col + 8'd1;
                    end
                endcase
            end
        end

        cell_index_next = index_full[10:0];
        cell_char_next  = char_in.char_code | (cur_underline ? UNDERLINE_BIT : 8'h00);
        fg_color_next   = cur_special ? special_color_reg : text_color_reg;
        bg_color_next   = cur_highlight ? highlight_color_reg : background_reg;
    end

    // Hold string state; advance on each accepted character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg   <= '0;
            cursor_row_reg   <= '0;
            special_on_reg   <= 1'b0;
            highlight_on_reg <= 1'b0;
            underline_on_reg <= 1'b0;
            stopped_reg      <= 1'b1;
        end
        else if (in_accept)
        begin
            cursor_col_reg   <= cursor_col_next;
            cursor_row_reg   <= cursor_row_next;
            special_on_reg   <= special_on_next;
            highlight_on_reg <= highlight_on_next;
            underline_on_reg <= underline_on_next;
            stopped_reg      <= stopped_next;
        end
    end

    // Output request valid: set by a cell write, cleared once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= write_cell;
        end
        else if (cell_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (in_accept && write_cell)
        begin
            cell_index_reg <= cell_index_next;
            cell_char_reg  <= cell_char_next;
            fg_color_reg   <= fg_color_next;
            bg_color_reg   <= bg_color_next;
        end
    end

    assign cell_out.valid         = out_valid_reg;
    assign cell_out.cell_index    = cell_index_reg;
    assign cell_out.cell_char     = cell_char_reg;
    assign cell_out.cell_fg_color = fg_color_reg;
    assign cell_out.cell_bg_color = bg_color_reg;

endmodule

`default_nettype wire

FILE: design/tmcw_checker.sv
// Port-level assertions for the text markup cell writer, with their bind.
`timescale 1ns / 1ps
`default_nettype none

module tmcw_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire tmcw_pkg::cell_index_t cell_index,
    input wire tmcw_pkg::char_t    cell_char,
    input wire tmcw_pkg::color_t   cell_fg_color,
    input wire tmcw_pkg::color_t   cell_bg_color
);
    // A stalled cell request keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cell_index)
            && $stable(cell_char) && $stable(cell_fg_color) && $stable(cell_bg_color))
        else $error("stalled cell request changed");

    // A new cell request follows an accepted character
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("cell request without a character");

    // An empty output stage never blocks the character side
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("character request stalled with empty output");

    // A taken request is not repeated without a new character
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !(in_valid && in_ready) |=> !out_valid)
        else $error("cell request repeated");

endmodule

bind text_markup_cell_writer tmcw_checker u_tmcw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (char_in.valid),
    .in_ready      (char_in.ready),
    .out_valid     (cell_out.valid),
    .out_ready     (cell_out.ready),
    .cell_index    (cell_out.cell_index),
    .cell_char     (cell_out.cell_char),
    .cell_fg_color (cell_out.cell_fg_color),
    .cell_bg_color (cell_out.cell_bg_color)
);

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Testbench for the text markup cell writer: random strings checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
    import tmcw_pkg::*;

    localparam int SCREEN_COLS   = 64;
    localparam int SCREEN_ROWS   = 32;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int NUM_PHASES    = 10;
    localparam cfg_index_t REG_SPARE_6 = 3'd6;
    localparam cfg_index_t REG_SPARE_7 = 3'd7;

    typedef struct packed {
        cell_index_t index;
        char_t       code;
        color_t      fg;
        color_t      bg;
    } cell_write_t;

    // Track screen state and the cell writes still owed by the block
    class cell_write_scoreboard;
        cell_write_t expected_cells[$];
        int          errors;
        color_t      text_color;
        color_t      special_color;
        color_t      background;
        color_t      highlight;
        cols_cfg_t   cols_in_use;
        rows_cfg_t   rows_in_use;
        int          cur_col;
        int          cur_row;
        bit          special_on;
        bit          highlight_on;
        bit          underline_on;
        bit          stopped;

        function new();
            errors        = 0;
            text_color    = '0;
            special_color = '0;
            background    = '0;
            highlight     = '0;
            cols_in_use   = COLUMNS_RESET;
            rows_in_use   = ROWS_RESET;
            cur_col       = 0;
            cur_row       = 0;
            special_on    = 1'b0;
            highlight_on  = 1'b0;
            underline_on  = 1'b0;
            stopped       = 1'b1;
        endfunction

        function void write_reg(cfg_index_t idx, color_t data);
            case (idx)
                REG_TEXT_COLOR:      text_color    = data;
                REG_SPECIAL_COLOR:   special_color = data;
                REG_BACKGROUND:      background    = data;
                REG_HIGHLIGHT_COLOR: highlight     = data;
                REG_COLUMNS_IN_USE:  cols_in_use   = data[6:0];
                REG_ROWS_IN_USE:     rows_in_use   = data[5:0];
                default: ;
            endcase
        endfunction

        // Predict the cell write, if any, caused by one accepted character
        function void note_char(char_t ch, logic first, start_col_t sc, start_row_t sr);
            int          col_bound;
            int          row_bound;
            cell_write_t entry;
            col_bound = (cols_in_use < SCREEN_COLS) ? int'(cols_in_use) : SCREEN_COLS;
            row_bound = (rows_in_use < SCREEN_ROWS) ? int'(rows_in_use) : SCREEN_ROWS;
            if (first)
            begin
                cur_col      = sc;
                cur_row      = sr;
                special_on   = 1'b0;
                highlight_on = 1'b0;
                underline_on = 1'b0;
                stopped      = 1'b0;
            end
            if (stopped)
                return;
            if (ch == CH_NUL || cur_col >= col_bound || cur_row >= row_bound)
            begin
                stopped = 1'b1;
                return;
            end
            case (ch)
                CH_CR, CH_LF:                  cur_row++;
                CH_SPECIAL_ON, CH_SPECIAL_OFF: special_on = (ch == CH_SPECIAL_ON);
                CH_HILITE_ON, CH_HILITE_OFF:   highlight_on = (ch == CH_HILITE_ON);
                CH_UNDERLINE:                  underline_on = !underline_on;
                default:
                begin
                    entry.index = cell_index_t'(cur_row * SCREEN_COLS + cur_col);
                    entry.code  = ch | (underline_on ? UNDERLINE_BIT : 8'h00);
                    entry.fg    = special_on ? special_color : text_color;
                    entry.bg    = highlight_on ? highlight : background;
                    expected_cells.push_back(entry);
                    cur_col++;
                end
            endcase
        endfunction

        // Compare one accepted cell write with the oldest prediction
        function void check_cell(cell_write_t got);
            cell_write_t want;
            if (expected_cells.size() == 0)
            begin
                $display("%0t: unexpected cell write: index %h char %h fg %h bg %h",
                         $time, got.index, got.code, got.fg, got.bg);
                errors++;
                return;
            end
            want = expected_cells.pop_front();
            if (got.index !== want.index)
            begin
                $display("%0t: cell_index mismatch: expected %h, got %h",
                         $time, want.index, got.index);
                errors++;
            end
            if (got.code !== want.code)
            begin
                $display("%0t: cell_char mismatch: expected %h, got %h",
                         $time, want.code, got.code);
                errors++;
            end
            if (got.fg !== want.fg)
            begin
                $display("%0t: cell_fg_color mismatch: expected %h, got %h",
                         $time, want.fg, got.fg);
                errors++;
            end
            if (got.bg !== want.bg)
            begin
                $display("%0t: cell_bg_color mismatch: expected %h, got %h",
                         $time, want.bg, got.bg);
                errors++;
            end
        endfunction

        function int pending();
            return expected_cells.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   stall_on;
    bit   hold_request;
    int   quiet_cycles;
    cell_write_scoreboard sb;

    tmcw_char_if char_bus ();
    tmcw_cell_if cell_bus ();
    tmcw_cfg_if  cfg_bus ();

    text_markup_cell_writer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_in  (char_bus),
        .cell_out (cell_bus),
        .cfg      (cfg_bus)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watch every request that crosses a channel
    always @(posedge clk)
    begin
        if (rst_n && sb != null)
        begin
            if (cell_bus.valid && cell_bus.ready)
                sb.check_cell('{cell_bus.cell_index, cell_bus.cell_char,
                                cell_bus.cell_fg_color, cell_bus.cell_bg_color});
            if (char_bus.valid && char_bus.ready)
                sb.note_char(char_bus.char_code, char_bus.first,
                             char_bus.start_col, char_bus.start_row);
            if (cfg_bus.valid && cfg_bus.ready)
                sb.write_reg(cfg_bus.index, cfg_bus.data);
        end
    end

    // Stop the run when no channel moves for too long
    always @(posedge clk)
    begin
        if ((char_bus.valid && char_bus.ready) || (cell_bus.valid && cell_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress, %0d cell writes outstanding", $time, sb.pending());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Cell write receiver: random stall bursts and one long hold-off on request
    initial
    begin
        bit hold_done;
        hold_done      = 1'b0;
        cell_bus.ready = 1'b0;
        forever
        begin
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                cell_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (stall_on && $urandom_range(0, 4) == 0)
            begin
                cell_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                cell_bus.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Offer one character request and hold it until taken
    task automatic send_char(input char_t ch, input logic first,
                             input start_col_t sc, input start_row_t sr);
        if (stall_on && $urandom_range(0, 5) == 0)
        begin
            char_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        char_bus.valid     <= 1'b1;
        char_bus.char_code <= ch;
        char_bus.first     <= first;
        char_bus.start_col <= sc;
        char_bus.start_row <= sr;
        do
            @(posedge clk);
        while (char_bus.ready !== 1'b1);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input color_t data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do
            @(posedge clk);
        while (cfg_bus.ready !== 1'b1);
    endtask

    // Write every register, spare indexes included, then drop the request
    task automatic program_screen(input color_t text, input color_t special,
                                  input color_t back, input color_t hl,
                                  input int cols, input int rows);
        cfg_write(REG_TEXT_COLOR, text);
        cfg_write(REG_SPARE_6, color_t'($urandom));
        cfg_write(REG_SPECIAL_COLOR, special);
        cfg_write(REG_BACKGROUND, back);
        cfg_write(REG_HIGHLIGHT_COLOR, hl);
        cfg_write(REG_COLUMNS_IN_USE, {9'($urandom), 7'(cols)});
        cfg_write(REG_ROWS_IN_USE, {10'($urandom), 6'(rows)});
        cfg_write(REG_SPARE_7, color_t'($urandom));
        cfg_bus.valid <= 1'b0;
    endtask

    // Drop the character request and wait until the block has gone idle
    task automatic drain();
        char_bus.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic char_t pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return CH_SPECIAL_ON;
        else if (r < 6)
            return CH_SPECIAL_OFF;
        else if (r < 8)
            return CH_HILITE_ON;
        else if (r < 10)
            return CH_HILITE_OFF;
        else if (r < 13)
            return CH_UNDERLINE;
        else if (r < 15)
            return CH_CR;
        else if (r < 17)
            return CH_LF;
        else if (r < 24)
            return char_t'($urandom_range(128, 255));
        else if (r < 25)
            return CH_NUL;
        else
            return char_t'($urandom_range(32, 126));
    endfunction

    // Send one string; mostly starting inside the screen, sometimes outside
    task automatic send_string(input int col_bound, input int row_bound, inout int sent);
        int len;
        int sc;
        int sr;
        int k;
        if (col_bound == 0 || $urandom_range(0, 9) == 0)
            sc = $urandom_range(0, 63);
        else
            sc = $urandom_range(0, col_bound - 1);
        if (row_bound == 0 || $urandom_range(0, 9) == 0)
            sr = $urandom_range(0, 31);
        else
            sr = $urandom_range(0, row_bound - 1);
        len = $urandom_range(1, 24);
        send_char(pick_char(), 1'b1, start_col_t'(sc), start_row_t'(sr));
        for (k = 1; k < len; k++)
            send_char(pick_char(), 1'b0, start_col_t'($urandom), start_row_t'($urandom));
        if ($urandom_range(0, 3) == 0)
        begin
            send_char(CH_NUL, 1'b0, start_col_t'($urandom), start_row_t'($urandom));
            len++;
        end
        sent += len;
    endtask

    function automatic void phase_plan(input int p, output int cols, output int rows,
                                       output int count);
        count = 220;
        case (p)
            0: begin cols = 64;  rows = 32; end
            1: begin cols = 1;   rows = 1;  count = 60; end
            2: begin cols = 127; rows = 63; end
            3: begin cols = 0;   rows = 32; count = 30; end
            4: begin cols = 64;  rows = 0;  count = 30; end
            5: begin cols = 37;  rows = 20; end
            6: begin cols = 8;   rows = 4;  end
            7: begin cols = 64;  rows = 32; end
            8: begin cols = $urandom_range(1, 64); rows = $urandom_range(1, 32); end
            default: begin cols = 64; rows = 5; end
        endcase
    endfunction

    // Directed part: markup, underline, line moves, screen edges and stops
    task automatic directed_strings();
        send_char("A", 1'b0, 6'd0, 5'd0);
        send_char("H", 1'b1, 6'd0, 5'd0);
        send_char(CH_UNDERLINE, 1'b0, 6'd0, 5'd0);
        send_char(8'hC1, 1'b0, 6'd63, 5'd31);
        send_char(CH_UNDERLINE, 1'b0, 6'd0, 5'd0);
        send_char(8'hFF, 1'b0, 6'd0, 5'd0);
        send_char(CH_SPECIAL_ON, 1'b0, 6'd0, 5'd0);
        send_char("b", 1'b0, 6'd0, 5'd0);
        send_char(CH_SPECIAL_OFF, 1'b0, 6'd0, 5'd0);
        send_char(CH_HILITE_ON, 1'b0, 6'd0, 5'd0);
        send_char("c", 1'b0, 6'd0, 5'd0);
        send_char(CH_HILITE_OFF, 1'b0, 6'd0, 5'd0);
        send_char(CH_CR, 1'b0, 6'd0, 5'd0);
        send_char("d", 1'b0, 6'd0, 5'd0);
        send_char(CH_LF, 1'b0, 6'd0, 5'd0);
        send_char("e", 1'b0, 6'd0, 5'd0);
        send_char("Z", 1'b1, 6'd63, 5'd31);
        send_char("Y", 1'b0, 6'd0, 5'd0);
        send_char("X", 1'b0, 6'd0, 5'd0);
        send_char(CH_SPECIAL_ON, 1'b1, 6'd10, 5'd31);
        send_char(CH_LF, 1'b0, 6'd0, 5'd0);
        send_char("q", 1'b0, 6'd0, 5'd0);
        send_char("a", 1'b1, 6'd3, 5'd4);
        send_char(CH_NUL, 1'b0, 6'd0, 5'd0);
        send_char("b", 1'b0, 6'd0, 5'd0);
    endtask

    // Main sequence
    initial
    begin
        int p;
        int cols;
        int rows;
        int count;
        int col_bound;
        int row_bound;
        int sent;
        int strings;
        rst_n              = 1'b0;
        stall_on           = 1'b1;
        hold_request       = 1'b0;
        char_bus.valid     = 1'b0;
        char_bus.char_code = '0;
        char_bus.first     = 1'b0;
        char_bus.start_col = '0;
        char_bus.start_row = '0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = REG_TEXT_COLOR;
        cfg_bus.data       = '0;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Default bounds first, with distinct colors
        program_screen(16'hF800, 16'h07E0, 16'h001F, 16'hFFE0, 64, 32);
        directed_strings();
        drain();

        for (p = 0; p < NUM_PHASES; p++)
        begin
            phase_plan(p, cols, rows, count);
            if (p == NUM_PHASES - 1)
                stall_on = 1'b0;
            if (p == 0)
                program_screen(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, cols, rows);
            else if (p == 1)
                program_screen(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, cols, rows);
            else
                program_screen(color_t'($urandom), color_t'($urandom), color_t'($urandom),
                               color_t'($urandom), cols, rows);
            col_bound = (cols < SCREEN_COLS) ? cols : SCREEN_COLS;
            row_bound = (rows < SCREEN_ROWS) ? rows : SCREEN_ROWS;
            sent      = 0;
            strings   = 0;
            while (sent < count)
            begin
                // Hold off the receiver once while strings keep coming
                if (p == 0 && strings == 5)
                    hold_request = 1'b1;
                if ($urandom_range(0, 9) == 0)
                    send_char(char_t'($urandom), 1'($urandom), start_col_t'($urandom),
                              start_row_t'($urandom));
                else
                    send_string(col_bound, row_bound, sent);
                strings++;
            end
            drain();
        end

        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
